FILE: src/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, character codes and helper functions of the string escape
// decoder.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int MAX_HELD_DIGITS_DEF = 16;

	// characters that the decoder reacts to or replays
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// UTF-8 encoding
	localparam logic [31:0] UTF_LIM1  = 32'h0000_0080;
	localparam logic [31:0] UTF_LIM2  = 32'h0000_0800;
	localparam logic [31:0] UTF_LIM3  = 32'h0001_0000;
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_LEAD4 = 8'hF0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;
	localparam logic [7:0]  UTF_MASK  = 8'h3F;

	// source of the byte loaded into the output register
	typedef enum logic [3:0] {
		SEL_BSL,
		SEL_FIRST,
		SEL_U,
		SEL_BRACE,
		SEL_HELD,
		SEL_CHAR,
		SEL_ESC,
		SEL_HEX,
		SEL_UTF
	} sel_t;

	typedef struct packed {
		logic       accept;
		logic       first_wr;
		logic       cp_clear;
		logic       digit_wr;
		logic       rd_en;
		logic       out_load;
		sel_t       sel;
		logic [1:0] utf_idx;
		logic       run_last;
		logic       string_done;
		logic       overflow;
	} cmd_t;

	typedef struct packed {
		logic       hex_ok;
		logic       is_bsl;
		logic       is_u;
		logic       is_lbrace;
		logic       is_rbrace;
		logic       is_esc;
		logic [1:0] utf_last;
	} sts_t;

	function automatic logic hex_ok(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic is_esc(input logic [7:0] c);
		return c == CH_N || c == CH_T || c == CH_R || c == CH_BSL ||
			c == CH_SQUOTE || c == CH_DQUOTE;
	endfunction

	function automatic logic [7:0] esc_byte(input logic [7:0] c);
		logic [7:0] b;
		case (c)
			CH_N:    b = CH_LF;
			CH_T:    b = CH_TAB;
			CH_R:    b = CH_CR;
			default: b = c;
		endcase
		return b;
	endfunction

	// number of UTF-8 bytes minus one
	function automatic logic [1:0] utf8_last(input logic [31:0] cp);
		logic [1:0] l;
		if (cp < UTF_LIM1) begin
			l = 2'd0;
		end else if (cp < UTF_LIM2) begin
			l = 2'd1;
		end else if (cp < UTF_LIM3) begin
			l = 2'd2;
		end else begin
			l = 2'd3;
		end
		return l;
	endfunction

	function automatic logic [7:0] utf8_cont(input logic [5:0] bits6);
		return UTF_CONT | ({2'b00, bits6} & UTF_MASK);
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [1:0] last,
		input logic [1:0] idx);
		logic [7:0] b;
		case (last)
			2'd0: b = cp[7:0];
			2'd1: b = (idx == 2'd0) ? (UTF_LEAD2 | {2'b00, cp[11:6]}) : utf8_cont(cp[5:0]);
			2'd2: begin
				case (idx)
					2'd0:    b = UTF_LEAD3 | cp[19:12];
					2'd1:    b = utf8_cont(cp[11:6]);
					default: b = utf8_cont(cp[5:0]);
				endcase
			end
			default: begin
				case (idx)
					2'd0:    b = UTF_LEAD4 | cp[25:18];
					2'd1:    b = utf8_cont(cp[17:12]);
					2'd2:    b = utf8_cont(cp[11:6]);
					default: b = utf8_cont(cp[5:0]);
				endcase
			end
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

FILE: src/wsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_in_if / wsd_out_if
// Valid/ready channels of the string escape decoder: raw bytes in, decoded
// bytes out.
// ----------------------------------------------------------------------------
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface wsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;
	logic       hold_overflow;

	modport source (output valid, output out_byte, output run_last, output string_done,
		output hold_overflow, input ready);
	modport sink (input valid, input out_byte, input run_last, input string_done,
		input hold_overflow, output ready);
endinterface
`default_nettype wire

FILE: src/wsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic                                         re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                                  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/wsd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_dp
// Datapath: input byte classification, hex/code point registers, held digit
// RAM and the output word register.
// ----------------------------------------------------------------------------
module wsd_dp #(
	parameter int MAX_HELD_DIGITS = wsd_pkg::MAX_HELD_DIGITS_DEF,
	localparam int AW = (MAX_HELD_DIGITS > 1) ? $clog2(MAX_HELD_DIGITS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    in_byte,
	input  wire wsd_pkg::cmd_t cmd,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] rd_addr,
	output wsd_pkg::sts_t      sts,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               string_done,
	output logic               hold_overflow
);

	logic [7:0]  first_q;
	logic [31:0] acc_q;
	logic [7:0]  char_q;
	logic [7:0]  held_rdata;
	logic [7:0]  chr;
	logic [7:0]  byte_d;

	wsd_ram #(
		.WIDTH(8),
		.DEPTH(MAX_HELD_DIGITS)
	) u_held (
		.clk  (clk),
		.we   (cmd.digit_wr),
		.waddr(wr_addr),
		.wdata(in_byte),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(held_rdata)
	);

	always_comb begin
		sts.hex_ok    = wsd_pkg::hex_ok(in_byte);
		sts.is_bsl    = (in_byte == wsd_pkg::CH_BSL);
		sts.is_u      = (in_byte == wsd_pkg::CH_U);
		sts.is_lbrace = (in_byte == wsd_pkg::CH_LBRACE);
		sts.is_rbrace = (in_byte == wsd_pkg::CH_RBRACE);
		sts.is_esc    = wsd_pkg::is_esc(in_byte);
		sts.utf_last  = wsd_pkg::utf8_last(acc_q);
	end

	// the breaking byte is live on the input only in the accept cycle
	assign chr = cmd.accept ? in_byte : char_q;

	always_comb begin
		case (cmd.sel)
			wsd_pkg::SEL_BSL:   byte_d = wsd_pkg::CH_BSL;
			wsd_pkg::SEL_FIRST: byte_d = first_q;
			wsd_pkg::SEL_U:     byte_d = wsd_pkg::CH_U;
			wsd_pkg::SEL_BRACE: byte_d = wsd_pkg::CH_LBRACE;
			wsd_pkg::SEL_HELD:  byte_d = held_rdata;
			wsd_pkg::SEL_CHAR:  byte_d = chr;
			wsd_pkg::SEL_ESC:   byte_d = wsd_pkg::esc_byte(in_byte);
			wsd_pkg::SEL_HEX:   byte_d = {wsd_pkg::hex_val(first_q), wsd_pkg::hex_val(in_byte)};
			wsd_pkg::SEL_UTF:   byte_d = wsd_pkg::utf8_byte(acc_q, sts.utf_last, cmd.utf_idx);
			default:            byte_d = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 8'h00;
			acc_q   <= 32'h0;
		end else begin
			if (cmd.first_wr) begin
				first_q <= in_byte;
			end
			if (cmd.cp_clear) begin
				acc_q <= 32'h0;
			end else if (cmd.digit_wr) begin
				acc_q <= {acc_q[27:0], wsd_pkg::hex_val(in_byte)};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= in_byte;
		end
		if (cmd.out_load) begin
			out_byte      <= byte_d;
			run_last      <= cmd.run_last;
			string_done   <= cmd.string_done;
			hold_overflow <= cmd.overflow;
		end
	end

endmodule
`default_nettype wire

FILE: src/wsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_ctrl
// Controller: escape mode machine, held digit count, and the sequencer that
// walks the replay / decoded / flush words of one input byte.
// ----------------------------------------------------------------------------
module wsd_ctrl #(
	parameter int MAX_HELD_DIGITS = wsd_pkg::MAX_HELD_DIGITS_DEF,
	localparam int AW = (MAX_HELD_DIGITS > 1) ? $clog2(MAX_HELD_DIGITS) : 1,
	localparam int CW = $clog2(MAX_HELD_DIGITS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          string_end,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire wsd_pkg::sts_t sts,
	output wsd_pkg::cmd_t      cmd,
	output logic [AW-1:0]      wr_addr,
	output logic [AW-1:0]      rd_addr
);

	typedef enum logic [2:0] {
		MODE_PLAIN,
		MODE_BSL,
		MODE_HEX1,
		MODE_U,
		MODE_UBRACE
	} mode_t;

	typedef enum logic [2:0] {
		MID_NONE,
		MID_CHAR,
		MID_ESC,
		MID_HEX,
		MID_UTF
	} mid_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BSL,
		ST_FIRST,
		ST_U,
		ST_BRACE,
		ST_HELD,
		ST_CHAR,
		ST_ESC,
		ST_HEX,
		ST_UTF
	} state_t;

	// ph: 0 while replaying the old escape or emitting the decoded word,
	// 1 while flushing the escape left open at string end
	typedef struct packed {
		state_t         st;
		logic           ph;
		logic [CW-1:0]  hi;
		logic [1:0]     ui;
	} step_t;

	localparam step_t STEP_START = '{st: ST_IDLE, ph: 1'b0, hi: '0, ui: 2'd0};

	function automatic step_t step_next(input step_t cur, input mode_t pre, input mid_t mid,
		input mode_t post, input logic [CW-1:0] n, input logic [1:0] ulast);
		step_t r;
		mode_t kind;
		logic  rep_end;
		logic  mid_end;
		r       = cur;
		rep_end = 1'b0;
		mid_end = 1'b0;
		kind    = cur.ph ? post : pre;
		case (cur.st)
			ST_IDLE: begin
				if (kind != MODE_PLAIN) begin
					r.st = ST_BSL;
				end else begin
					rep_end = 1'b1;
				end
			end
			ST_BSL: begin
				case (kind)
					MODE_HEX1:   r.st = ST_FIRST;
					MODE_U:      r.st = ST_U;
					MODE_UBRACE: r.st = ST_U;
					default:     rep_end = 1'b1;
				endcase
			end
			ST_FIRST: rep_end = 1'b1;
			ST_U: begin
				if (kind == MODE_UBRACE) begin
					r.st = ST_BRACE;
				end else begin
					rep_end = 1'b1;
				end
			end
			ST_BRACE: begin
				if (n != '0) begin
					r.st = ST_HELD;
					r.hi = '0;
				end else begin
					rep_end = 1'b1;
				end
			end
			ST_HELD: begin
				if (cur.hi + CW'(1) < n) begin
					r.hi = cur.hi + CW'(1);
				end else begin
					rep_end = 1'b1;
				end
			end
			ST_CHAR: mid_end = 1'b1;
			ST_ESC:  mid_end = 1'b1;
			ST_HEX:  mid_end = 1'b1;
			ST_UTF: begin
				if (cur.ui != ulast) begin
					r.ui = cur.ui + 2'd1;
				end else begin
					mid_end = 1'b1;
				end
			end
			default: r.st = ST_IDLE;
		endcase
		if (rep_end) begin
			if (!cur.ph) begin
				case (mid)
					MID_CHAR: r.st = ST_CHAR;
					MID_ESC:  r.st = ST_ESC;
					MID_HEX:  r.st = ST_HEX;
					MID_UTF: begin
						r.st = ST_UTF;
						r.ui = 2'd0;
					end
					default: mid_end = 1'b1;
				endcase
			end else begin
				r.st = ST_IDLE;
			end
		end
		if (mid_end) begin
			r.ph = 1'b1;
			r.st = (post != MODE_PLAIN) ? ST_BSL : ST_IDLE;
		end
		return r;
	endfunction

	// registers
	step_t         cur_q;
	mode_t         mode_q;
	logic [CW-1:0] count_q;
	mode_t         pre_q;
	mid_t          mid_q;
	mode_t         post_q;
	logic [CW-1:0] repn_q;
	logic          end_q;
	logic          ovf_q;
	logic          out_valid_q;

	// decode of the accepted byte
	mode_t         pre_d;
	mid_t          mid_d;
	mode_t         mode_n;
	mode_t         post_d;
	logic          plain_c;
	logic          first_wr;
	logic          cp_clear;
	logic          digit_wr;
	logic          cnt_clr;
	logic          ovf_d;
	logic [CW-1:0] cnt_upd;

	// sequencing
	logic          accept;
	logic          idle;
	logic          out_free;
	logic          has_emit;
	logic          load;
	step_t         start;
	step_t         emit;
	step_t         nx;
	mode_t         pre_c;
	mid_t          mid_c;
	mode_t         post_c;
	logic [CW-1:0] repn_c;
	logic          end_c;
	logic          ovf_c;
	wsd_pkg::sel_t sel;

	always_comb begin
		pre_d    = MODE_PLAIN;
		mid_d    = MID_NONE;
		mode_n   = mode_q;
		plain_c  = 1'b0;
		first_wr = 1'b0;
		cp_clear = 1'b0;
		digit_wr = 1'b0;
		cnt_clr  = 1'b0;
		ovf_d    = 1'b0;
		case (mode_q)
			MODE_BSL: begin
				mode_n = MODE_PLAIN;
				if (sts.is_esc) begin
					mid_d = MID_ESC;
				end else if (sts.is_u) begin
					mode_n = MODE_U;
				end else if (sts.hex_ok) begin
					mode_n   = MODE_HEX1;
					first_wr = 1'b1;
				end else begin
					pre_d   = MODE_BSL;
					plain_c = 1'b1;
				end
			end
			MODE_HEX1: begin
				if (sts.hex_ok) begin
					mid_d  = MID_HEX;
					mode_n = MODE_PLAIN;
				end else begin
					pre_d   = MODE_HEX1;
					plain_c = 1'b1;
				end
			end
			MODE_U: begin
				if (sts.is_lbrace) begin
					mode_n   = MODE_UBRACE;
					cp_clear = 1'b1;
					cnt_clr  = 1'b1;
				end else begin
					pre_d   = MODE_U;
					plain_c = 1'b1;
				end
			end
			MODE_UBRACE: begin
				if (sts.is_rbrace) begin
					mid_d   = MID_UTF;
					mode_n  = MODE_PLAIN;
					cnt_clr = 1'b1;
				end else if (sts.hex_ok && count_q < CW'(MAX_HELD_DIGITS)) begin
					digit_wr = 1'b1;
				end else begin
					ovf_d   = sts.hex_ok;
					pre_d   = MODE_UBRACE;
					plain_c = 1'b1;
				end
			end
			default: plain_c = 1'b1;
		endcase
		if (plain_c) begin
			if (sts.is_bsl) begin
				mode_n = MODE_BSL;
			end else begin
				mode_n = MODE_PLAIN;
				mid_d  = MID_CHAR;
			end
		end
		cnt_upd = cnt_clr ? '0 : (digit_wr ? count_q + CW'(1) : count_q);
		post_d  = string_end ? mode_n : MODE_PLAIN;
	end

	assign idle     = (cur_q.st == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = idle && out_free;
	assign accept   = in_valid && in_ready;

	// plan of the word sequence: fresh in the accept cycle, registered after
	assign pre_c  = accept ? pre_d : pre_q;
	assign mid_c  = accept ? mid_d : mid_q;
	assign post_c = accept ? post_d : post_q;
	assign repn_c = accept ? cnt_upd : repn_q;
	assign end_c  = accept ? string_end : end_q;
	assign ovf_c  = accept ? ovf_d : ovf_q;

	always_comb begin
		start    = step_next(STEP_START, pre_d, mid_d, post_d, cnt_upd, sts.utf_last);
		emit     = idle ? start : cur_q;
		has_emit = idle ? (accept && start.st != ST_IDLE) : 1'b1;
		load     = has_emit && out_free;
		nx       = step_next(emit, pre_c, mid_c, post_c, repn_c, sts.utf_last);
	end

	always_comb begin
		case (emit.st)
			ST_BSL:   sel = wsd_pkg::SEL_BSL;
			ST_FIRST: sel = wsd_pkg::SEL_FIRST;
			ST_U:     sel = wsd_pkg::SEL_U;
			ST_BRACE: sel = wsd_pkg::SEL_BRACE;
			ST_HELD:  sel = wsd_pkg::SEL_HELD;
			ST_CHAR:  sel = wsd_pkg::SEL_CHAR;
			ST_ESC:   sel = wsd_pkg::SEL_ESC;
			ST_HEX:   sel = wsd_pkg::SEL_HEX;
			ST_UTF:   sel = wsd_pkg::SEL_UTF;
			default:  sel = wsd_pkg::SEL_CHAR;
		endcase
	end

	always_comb begin
		cmd.accept      = accept;
		cmd.first_wr    = accept && first_wr;
		cmd.cp_clear    = accept && cp_clear;
		cmd.digit_wr    = accept && digit_wr;
		// prefetch the next held digit as the current word leaves
		cmd.rd_en       = load && (nx.st == ST_HELD);
		cmd.out_load    = load;
		cmd.sel         = sel;
		cmd.utf_idx     = emit.ui;
		cmd.run_last    = (nx.st == ST_IDLE);
		cmd.string_done = (nx.st == ST_IDLE) && end_c;
		cmd.overflow    = ovf_c;
	end

	assign wr_addr   = count_q[AW-1:0];
	assign rd_addr   = nx.hi[AW-1:0];
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= STEP_START;
			mode_q      <= MODE_PLAIN;
			count_q     <= '0;
			pre_q       <= MODE_PLAIN;
			mid_q       <= MID_NONE;
			post_q      <= MODE_PLAIN;
			repn_q      <= '0;
			end_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pre_q   <= pre_d;
				mid_q   <= mid_d;
				post_q  <= post_d;
				repn_q  <= cnt_upd;
				end_q   <= string_end;
				ovf_q   <= ovf_d;
				mode_q  <= string_end ? MODE_PLAIN : mode_n;
				count_q <= (string_end || pre_d != MODE_PLAIN) ? '0 : cnt_upd;
				if (start.st != ST_IDLE) begin
					cur_q <= nx;
				end
			end else if (!idle && load) begin
				cur_q <= nx;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/wat_string_escape_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wat_string_escape_decoder
// Decodes escapes in the body of a quoted text-format string, one raw byte in,
// zero or more decoded bytes out.
// ----------------------------------------------------------------------------
// A raw byte is taken on raw and yields zero or more words on decoded; the
// last word of each byte carries run_last, and the last word of a byte marked
// string_end carries string_done. An input byte holds the block until its
// last word is loaded: the first word is loaded into the output register in
// the accept cycle and the controller's sequencer loads one more word per
// cycle after that, so plain text runs at one byte per cycle when decoded
// does not stall. Most bytes yield one word or none; a closing brace
// yields up to four UTF-8 words, and a malformed escape, a digit past the
// MAX_HELD_DIGITS limit or a string end inside an open escape replays the
// escape literally, up to MAX_HELD_DIGITS + 4 words, its held hex digits read
// back one per cycle from the held-digit RAM. Back-pressure on decoded stalls
// the sequencer and, with it, raw.
module wat_string_escape_decoder #(
	parameter int MAX_HELD_DIGITS = wsd_pkg::MAX_HELD_DIGITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wsd_in_if.sink     raw,
	wsd_out_if.source  decoded
);

	localparam int AW = (MAX_HELD_DIGITS > 1) ? $clog2(MAX_HELD_DIGITS) : 1;

	wsd_pkg::cmd_t cmd;
	wsd_pkg::sts_t sts;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	wsd_ctrl #(
		.MAX_HELD_DIGITS(MAX_HELD_DIGITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (raw.valid),
		.in_ready  (raw.ready),
		.string_end(raw.string_end),
		.out_valid (decoded.valid),
		.out_ready (decoded.ready),
		.sts       (sts),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	wsd_dp #(
		.MAX_HELD_DIGITS(MAX_HELD_DIGITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (raw.in_byte),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.sts          (sts),
		.out_byte     (decoded.out_byte),
		.run_last     (decoded.run_last),
		.string_done  (decoded.string_done),
		.hold_overflow(decoded.hold_overflow)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb_wat_string_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wat_string_escape_decoder
// Self-checking bench for the string escape decoder. Raw bytes are pushed
// through the raw channel and the predicted decoded words are compared, field
// by field, with those on the decoded channel. A short directed sequence hits
// each escape form, then random escape sequences run under random idling and
// back-pressure.
// ----------------------------------------------------------------------------
module tb_wat_string_escape_decoder;
	import wsd_pkg::*;

	localparam int HELD_MAX   = MAX_HELD_DIGITS_DEF;
	localparam int LONG_STALL = 250;

	typedef enum logic [2:0] {
		ESC_PLAIN,
		ESC_BSL,
		ESC_HEX1,
		ESC_U,
		ESC_UBRACE
	} esc_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} raw_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
		logic       hold_overflow;
	} dec_word_t;

	logic clk;
	logic arst_n;

	wsd_in_if  raw_ch ();
	wsd_out_if dec_ch ();

	wat_string_escape_decoder #(.MAX_HELD_DIGITS(HELD_MAX)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.decoded (dec_ch)
	);

	raw_item_t raw_pending[$];
	dec_word_t expected_words[$];
	int        queued_total;
	int        fail_count;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        stall_left;
	logic      stall_req;
	logic      stall_done;

	// decoder state as predicted
	esc_mode_t   mode_q;
	logic [7:0]  first_digit;
	logic [31:0] cp_acc;
	logic [7:0]  digit_hold [HELD_MAX];
	int          n_held;
	logic [7:0]  burst[$];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#4_000_000;
		$display("tb_wat_string_escape_decoder NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------- predictor
	function automatic int digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] cont_byte(input logic [31:0] cp, input int sh);
		logic [31:0] t;
		t = cp >> sh;
		return UTF_CONT | {2'b00, t[5:0]};
	endfunction

	task automatic emit_word(input logic [7:0] b);
		burst.push_back(b);
	endtask

	task automatic replay_escape();
		case (mode_q)
			ESC_BSL: emit_word(CH_BSL);
			ESC_HEX1: begin
				emit_word(CH_BSL);
				emit_word(first_digit);
			end
			ESC_U: begin
				emit_word(CH_BSL);
				emit_word(CH_U);
			end
			ESC_UBRACE: begin
				emit_word(CH_BSL);
				emit_word(CH_U);
				emit_word(CH_LBRACE);
				for (int k = 0; k < n_held; k++)
					emit_word(digit_hold[k]);
			end
			default: ;
		endcase
		mode_q = ESC_PLAIN;
		n_held = 0;
	endtask

	task automatic take_plain(input logic [7:0] c);
		if (c == CH_BSL) begin
			mode_q = ESC_BSL;
		end else begin
			mode_q = ESC_PLAIN;
			emit_word(c);
		end
	endtask

	task automatic encode_utf8(input logic [31:0] cp);
		logic [31:0] lead;
		if (cp < UTF_LIM1) begin
			emit_word(cp[7:0]);
		end else if (cp < UTF_LIM2) begin
			lead = {24'h0, UTF_LEAD2} | (cp >> 6);
			emit_word(lead[7:0]);
			emit_word(cont_byte(cp, 0));
		end else if (cp < UTF_LIM3) begin
			lead = {24'h0, UTF_LEAD3} | (cp >> 12);
			emit_word(lead[7:0]);
			emit_word(cont_byte(cp, 6));
			emit_word(cont_byte(cp, 0));
		end else begin
			// lead byte keeps only its low eight bits
			lead = {24'h0, UTF_LEAD4} | (cp >> 18);
			emit_word(lead[7:0]);
			emit_word(cont_byte(cp, 12));
			emit_word(cont_byte(cp, 6));
			emit_word(cont_byte(cp, 0));
		end
	endtask

	task automatic decode_byte(input logic [7:0] c, input logic fin);
		int        d;
		int        fd;
		logic      ovf;
		dec_word_t w;
		d = digit_of(c);
		ovf = 1'b0;
		burst.delete();
		case (mode_q)
			ESC_BSL: begin
				mode_q = ESC_PLAIN;
				if (c == CH_N) begin
					emit_word(CH_LF);
				end else if (c == CH_T) begin
					emit_word(CH_TAB);
				end else if (c == CH_R) begin
					emit_word(CH_CR);
				end else if (c == CH_BSL || c == CH_SQUOTE || c == CH_DQUOTE) begin
					emit_word(c);
				end else if (c == CH_U) begin
					mode_q = ESC_U;
				end else if (d >= 0) begin
					first_digit = c;
					mode_q = ESC_HEX1;
				end else begin
					emit_word(CH_BSL);
					take_plain(c);
				end
			end
			ESC_HEX1: begin
				if (d >= 0) begin
					fd = digit_of(first_digit);
					emit_word(8'(fd * 16 + d));
					mode_q = ESC_PLAIN;
				end else begin
					replay_escape();
					take_plain(c);
				end
			end
			ESC_U: begin
				if (c == CH_LBRACE) begin
					mode_q = ESC_UBRACE;
					cp_acc = '0;
					n_held = 0;
				end else begin
					replay_escape();
					take_plain(c);
				end
			end
			ESC_UBRACE: begin
				if (c == CH_RBRACE) begin
					encode_utf8(cp_acc);
					mode_q = ESC_PLAIN;
					n_held = 0;
				end else if (d >= 0 && n_held < HELD_MAX) begin
					digit_hold[n_held] = c;
					n_held++;
					cp_acc = cp_acc * 32'd16 + 32'(d);
				end else begin
					ovf = (d >= 0);
					replay_escape();
					take_plain(c);
				end
			end
			default: take_plain(c);
		endcase
		if (fin)
			replay_escape();
		foreach (burst[k]) begin
			w.out_byte = burst[k];
			w.run_last = (k == burst.size() - 1);
			w.string_done = w.run_last && fin;
			w.hold_overflow = ovf;
			expected_words.push_back(w);
		end
	endtask

	// ---------------------------------------------------------------- stimulus
	task automatic queue_byte(input logic [7:0] c, input logic fin);
		raw_item_t it;
		it.data = c;
		it.fin = fin;
		raw_pending.push_back(it);
		queued_total++;
	endtask

	// random string_end on roughly one byte in fourteen
	task automatic queue_rand_end(input logic [7:0] c);
		queue_byte(c, $urandom_range(13) == 0);
	endtask

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(21);
		if (v < 10)
			return 8'(int'("0") + v);
		if (v < 16)
			return 8'(int'("a") + v - 10);
		return 8'(int'("A") + v - 16);
	endfunction

	function automatic logic [7:0] rand_nonhex();
		logic [7:0] v;
		v = 8'($urandom_range(255));
		while (digit_of(v) >= 0)
			v = 8'($urandom_range(255));
		return v;
	endfunction

	function automatic logic [7:0] rand_simple_esc();
		case ($urandom_range(5))
			0: return CH_N;
			1: return CH_T;
			2: return CH_R;
			3: return CH_BSL;
			4: return CH_SQUOTE;
			default: return CH_DQUOTE;
		endcase
	endfunction

	function automatic int rand_digit_count();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return HELD_MAX;
		if (r < 3)
			return $urandom_range(8);
		return $urandom_range(5);
	endfunction

	task automatic queue_ubrace_open();
		queue_rand_end(CH_BSL);
		queue_rand_end(CH_U);
		queue_rand_end(CH_LBRACE);
	endtask

	task automatic add_segment();
		int         kind;
		int         n;
		logic [7:0] c;
		kind = $urandom_range(99);
		if (kind < 30) begin
			c = 8'($urandom_range(255));
			if (c == CH_BSL)
				c = 8'($urandom_range(32, 126));
			queue_rand_end(c);
		end else if (kind < 42) begin
			queue_rand_end(CH_BSL);
			queue_rand_end(rand_simple_esc());
		end else if (kind < 52) begin
			queue_rand_end(CH_BSL);
			queue_rand_end(rand_hex_char());
			queue_rand_end(rand_hex_char());
		end else if (kind < 72) begin
			n = rand_digit_count();
			queue_ubrace_open();
			repeat (n)
				queue_rand_end(rand_hex_char());
			queue_rand_end(CH_RBRACE);
		end else if (kind < 77) begin
			// one digit past the hold limit
			queue_ubrace_open();
			repeat (HELD_MAX + 1)
				queue_rand_end(rand_hex_char());
			if ($urandom_range(1))
				queue_rand_end(CH_RBRACE);
		end else if (kind < 90) begin
			case ($urandom_range(4))
				0: begin
					c = rand_nonhex();
					while (c == CH_N || c == CH_T || c == CH_R || c == CH_BSL ||
						c == CH_SQUOTE || c == CH_DQUOTE || c == CH_U)
						c = rand_nonhex();
					queue_rand_end(CH_BSL);
					queue_rand_end(c);
				end
				1: begin
					queue_rand_end(CH_BSL);
					queue_rand_end(rand_hex_char());
					queue_rand_end(rand_nonhex());
				end
				2: begin
					c = 8'($urandom_range(255));
					if (c == CH_LBRACE)
						c = CH_BSL;
					queue_rand_end(CH_BSL);
					queue_rand_end(CH_U);
					queue_rand_end(c);
				end
				3: begin
					c = rand_nonhex();
					if (c == CH_RBRACE)
						c = CH_BSL;
					queue_ubrace_open();
					repeat ($urandom_range(4))
						queue_rand_end(rand_hex_char());
					queue_rand_end(c);
				end
				default: begin
					// string ends inside an open code point escape
					queue_ubrace_open();
					repeat ($urandom_range(5))
						queue_rand_end(rand_hex_char());
					queue_byte(rand_hex_char(), 1'b1);
				end
			endcase
		end else begin
			repeat ($urandom_range(1, 4))
				queue_rand_end(8'($urandom_range(255)));
		end
	endtask

	task automatic queue_random(input int count);
		int goal;
		goal = queued_total + count;
		while (queued_total < goal)
			add_segment();
	endtask

	task automatic wait_drained();
		while (raw_pending.size() != 0 || raw_ch.valid || expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic flag_failure(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	// ---------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		raw_item_t nxt;
		if (!arst_n) begin
			raw_ch.valid <= 1'b0;
			raw_ch.in_byte <= '0;
			raw_ch.string_end <= 1'b0;
		end else begin
			if (raw_ch.valid && raw_ch.ready)
				decode_byte(raw_ch.in_byte, raw_ch.string_end);
			if (!raw_ch.valid || raw_ch.ready) begin
				if (raw_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = raw_pending.pop_front();
					raw_ch.valid <= 1'b1;
					raw_ch.in_byte <= nxt.data;
					raw_ch.string_end <= nxt.fin;
				end else begin
					raw_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_req && !stall_done) begin
			stall_left <= LONG_STALL;
			stall_done <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk or negedge arst_n) begin
		dec_word_t got;
		dec_word_t want;
		if (!arst_n) begin
			dec_ch.ready <= 1'b0;
		end else begin
			if (dec_ch.valid && dec_ch.ready) begin
				got = {dec_ch.out_byte, dec_ch.run_last, dec_ch.string_done,
					dec_ch.hold_overflow};
				if (expected_words.size() == 0) begin
					flag_failure($sformatf("unexpected word: byte %02h last %0b done %0b ovf %0b",
						got.out_byte, got.run_last, got.string_done, got.hold_overflow));
				end else begin
					want = expected_words.pop_front();
					if (got !== want)
						flag_failure({
							$sformatf("word mismatch: exp byte %02h last %0b done %0b ovf %0b",
								want.out_byte, want.run_last, want.string_done,
								want.hold_overflow),
							$sformatf(", got byte %02h last %0b done %0b ovf %0b",
								got.out_byte, got.run_last, got.string_done,
								got.hold_overflow)});
				end
			end
			dec_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		raw_ch.valid = 1'b0;
		raw_ch.in_byte = '0;
		raw_ch.string_end = 1'b0;
		dec_ch.ready = 1'b0;
		arst_n = 1'b0;
		mode_q = ESC_PLAIN;
		first_digit = '0;
		cp_acc = '0;
		n_held = 0;
		queued_total = 0;
		fail_count = 0;
		stall_req = 1'b0;
		send_idle_pct = 21;
		recv_idle_pct = 52;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes, every escape, malformed forms, end mid-escape
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_N, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_T, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_R, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_BSL, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_SQUOTE, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_DQUOTE, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte("a", 1'b0); queue_byte("F", 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_U, 1'b0);
		queue_byte(CH_LBRACE, 1'b0); queue_byte(CH_RBRACE, 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte("q", 1'b0);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_U, 1'b0); queue_byte("x", 1'b1);
		queue_byte(CH_BSL, 1'b0); queue_byte(CH_U, 1'b1);
		queue_random(100);
		wait_drained();

		// sender pauses here until every word is back
		send_idle_pct = 52;
		recv_idle_pct = 21;
		queue_random(100);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(90);
		stall_req = 1'b1;
		wait_drained();

		repeat (HELD_MAX + 24) @(negedge clk);
		if (fail_count == 0 && expected_words.size() == 0)
			$display("tb_wat_string_escape_decoder OK");
		else
			$display("tb_wat_string_escape_decoder NOT OK");
		$finish;
	end

endmodule

FILE: files.f
src/wsd_pkg.sv
src/wsd_if.sv
src/wsd_ram.sv
src/wsd_dp.sv
src/wsd_ctrl.sv
src/wat_string_escape_decoder.sv
tb/sv/tb_wat_string_escape_decoder.sv
